// File: src/fbpa_pkg.sv
// Package for the fixed block pool allocator: types, codes and constants.
`default_nettype none

package fbpa_pkg;

    // Sizes of the request and result fields
    localparam int INDEX_W     = 8;
    localparam int ADDR_W      = 32;
    localparam int OBJ_SIZE_W  = 13;
    localparam int LIMIT_W     = 9;
    localparam int REQ_SIZE_W  = 16;
    localparam int PRODUCT_W   = INDEX_W + OBJ_SIZE_W;

    // One link entry: end-of-list flag over the next index
    localparam int LINK_W      = INDEX_W + 1;

    // Largest index span the 8-bit index can reach
    localparam int INDEX_SPAN  = 1 << INDEX_W;

    // Default number of blocks in the pool
    localparam int POOL_BLOCKS_DEFAULT = 256;

    // Smallest block: one link must fit in a free block
    localparam logic [OBJ_SIZE_W-1:0] LINK_BYTES = OBJ_SIZE_W'(8);

    // Register reset values
    localparam logic [ADDR_W-1:0]     POOL_BASE_RESET   = '0;
    localparam logic [OBJ_SIZE_W-1:0] OBJECT_SIZE_RESET = OBJ_SIZE_W'(8);
    localparam logic [LIMIT_W-1:0]    BLOCK_LIMIT_RESET = LIMIT_W'(256);

    // Configuration register map
    localparam int APB_ADDR_W = 4;
    localparam logic [APB_ADDR_W-1:0] REG_POOL_BASE   = 4'h0;
    localparam logic [APB_ADDR_W-1:0] REG_OBJECT_SIZE = 4'h4;
    localparam logic [APB_ADDR_W-1:0] REG_BLOCK_LIMIT = 4'h8;

    typedef enum logic [0:0] {
        OP_ALLOC = 1'b0,
        OP_FREE  = 1'b1
    } t_opcode;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_EXHAUSTED = 2'd1,
        ST_TOO_LARGE = 2'd2,
        ST_BAD_FREE  = 2'd3
    } t_status;

    typedef enum logic [0:0] {
        S_IDLE = 1'b0,
        S_LINK = 1'b1
    } t_state;

endpackage

`default_nettype wire

// File: src/fixed_block_pool_allocator.sv
// Fixed-size block pool allocator: free list in a link RAM plus a bump index.
//
//  Channel  | Direction | Handshake                  | Payload
//  ---------+-----------+----------------------------+-------------------------------------
//  request  | in        | i_in_valid / o_in_stall    | opcode, request_size, free_index
//  result   | out       | o_out_valid / i_out_stall  | status, block_index, block_address
//  config   | in/out    | APB psel/penable/pready    | pool_base, object_size, block_limit
//
// A free, a bump allocation and every error leave the state in S_IDLE. A pop
// from the free list moves to S_LINK, which holds the request side: the
// registered link RAM read must return before the new list head is known.
// The result register parts the two sides: a request is taken while a
// result waits, as long as that result leaves in the same cycle.
// Reset is synchronous; the link RAM is not cleared (a free writes it first).
`default_nettype none

module fixed_block_pool_allocator #(
    parameter int POOL_BLOCKS = fbpa_pkg::POOL_BLOCKS_DEFAULT
) (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,

    // request channel
    input  wire logic                                i_in_valid,
    output logic                                     o_in_stall,
    input  wire logic                                i_opcode,
    input  wire logic [fbpa_pkg::REQ_SIZE_W-1:0]     i_request_size,
    input  wire logic [fbpa_pkg::INDEX_W-1:0]        i_free_index,

    // result channel
    output logic                                     o_out_valid,
    input  wire logic                                i_out_stall,
    output logic      [1:0]                          o_status,
    output logic      [fbpa_pkg::INDEX_W-1:0]        o_block_index,
    output logic      [fbpa_pkg::ADDR_W-1:0]         o_block_address,

    // configuration port
    input  wire logic                                psel,
    input  wire logic                                penable,
    input  wire logic                                pwrite,
    input  wire logic [fbpa_pkg::APB_ADDR_W-1:0]     paddr,
    input  wire logic [31:0]                         pwdata,
    output logic      [31:0]                         prdata,
    output logic                                     pready
);

    // Link RAM only needs the blocks an 8-bit index can name
    localparam int DEPTH = (POOL_BLOCKS < fbpa_pkg::INDEX_SPAN) ?
                           POOL_BLOCKS : fbpa_pkg::INDEX_SPAN;
    localparam int AW    = $clog2(DEPTH);
    localparam logic [fbpa_pkg::LIMIT_W-1:0] LimCap = fbpa_pkg::LIMIT_W'(DEPTH);

    // configuration registers
    logic [fbpa_pkg::ADDR_W-1:0]     r_pool_base;
    logic [fbpa_pkg::OBJ_SIZE_W-1:0] r_object_size;
    logic [fbpa_pkg::LIMIT_W-1:0]    r_block_limit;

    // allocator state
    fbpa_pkg::t_state                r_state, n_state;
    logic [fbpa_pkg::INDEX_W-1:0]    r_head, n_head;
    logic                            r_nonempty, n_nonempty;
    logic [fbpa_pkg::LIMIT_W-1:0]    r_bump, n_bump;

    // result register
    logic                            r_out_valid, n_out_valid;
    logic [1:0]                      r_status, n_status;
    logic [fbpa_pkg::INDEX_W-1:0]    r_index, n_index;
    logic [fbpa_pkg::ADDR_W-1:0]     r_address, n_address;

    // link RAM access
    logic                            ram_we, ram_re;
    logic [AW-1:0]                   ram_waddr, ram_raddr;
    logic [fbpa_pkg::LINK_W-1:0]     ram_wdata, ram_rdata;

    // datapath helpers
    logic                            accept, cfg_write;
    logic [fbpa_pkg::LIMIT_W-1:0]    eff_limit;
    logic [fbpa_pkg::OBJ_SIZE_W-1:0] block_size;
    logic                            too_large, head_ok, bump_ok, bad_free;
    logic [fbpa_pkg::INDEX_W-1:0]    grant_index;
    logic [fbpa_pkg::PRODUCT_W-1:0]  offset;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pool_base   <= fbpa_pkg::POOL_BASE_RESET;
            r_object_size <= fbpa_pkg::OBJECT_SIZE_RESET;
            r_block_limit <= fbpa_pkg::BLOCK_LIMIT_RESET;
        end else if (cfg_write) begin
            unique case (paddr)
                fbpa_pkg::REG_POOL_BASE:   r_pool_base   <= pwdata;
                fbpa_pkg::REG_OBJECT_SIZE: r_object_size <= pwdata[fbpa_pkg::OBJ_SIZE_W-1:0];
                fbpa_pkg::REG_BLOCK_LIMIT: r_block_limit <= pwdata[fbpa_pkg::LIMIT_W-1:0];
                default: ;
            endcase
        end
    end

    // configuration reads
    always_comb begin
        unique case (paddr)
            fbpa_pkg::REG_POOL_BASE:   prdata = r_pool_base;
            fbpa_pkg::REG_OBJECT_SIZE: prdata = 32'(r_object_size);
            fbpa_pkg::REG_BLOCK_LIMIT: prdata = 32'(r_block_limit);
            default:                   prdata = '0;
        endcase
    end

    // handshake
    assign o_in_stall = !((r_state == fbpa_pkg::S_IDLE) && (!r_out_valid || !i_out_stall));
    assign accept     = i_in_valid && !o_in_stall;

    // limits and block geometry
    assign eff_limit  = (r_block_limit > LimCap) ? LimCap : r_block_limit;
    assign block_size = (r_object_size < fbpa_pkg::LINK_BYTES) ?
                        fbpa_pkg::LINK_BYTES : r_object_size;
    assign too_large  = i_request_size >
                        fbpa_pkg::REQ_SIZE_W'(r_object_size);
    assign head_ok    = fbpa_pkg::LIMIT_W'(r_head) < LimCap;
    assign bump_ok    = r_bump < eff_limit;
    assign bad_free   = fbpa_pkg::LIMIT_W'(i_free_index) >= eff_limit;

    // index handed out on a pop or a bump, and its byte offset
    assign grant_index = (r_nonempty && head_ok) ? r_head : r_bump[fbpa_pkg::INDEX_W-1:0];
    assign offset      = fbpa_pkg::PRODUCT_W'(grant_index) *
                         fbpa_pkg::PRODUCT_W'(block_size);

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            fbpa_pkg::S_IDLE: begin
                if (accept && (i_opcode == fbpa_pkg::OP_ALLOC) && !too_large &&
                    r_nonempty && head_ok) begin
                    n_state = fbpa_pkg::S_LINK;
                end
            end
            fbpa_pkg::S_LINK: begin
                n_state = fbpa_pkg::S_IDLE;
            end
            default: n_state = fbpa_pkg::S_IDLE;
        endcase
    end

    // request processing and list updates
    always_comb begin
        n_head      = r_head;
        n_nonempty  = r_nonempty;
        n_bump      = r_bump;
        n_out_valid = r_out_valid && i_out_stall;
        n_status    = r_status;
        n_index     = r_index;
        n_address   = r_address;
        ram_we      = 1'b0;
        ram_waddr   = i_free_index[AW-1:0];
        ram_wdata   = {!r_nonempty, r_head};
        ram_re      = 1'b0;
        ram_raddr   = r_head[AW-1:0];

        // popped block's link comes back from the RAM
        if (r_state == fbpa_pkg::S_LINK) begin
            n_head     = ram_rdata[fbpa_pkg::INDEX_W-1:0];
            n_nonempty = !ram_rdata[fbpa_pkg::INDEX_W];
        end

        if (accept) begin
            n_out_valid = 1'b1;
            n_status    = fbpa_pkg::ST_OK;
            n_index     = '0;
            n_address   = '0;
            if (i_opcode == fbpa_pkg::OP_ALLOC) begin
                if (too_large) begin
                    n_status = fbpa_pkg::ST_TOO_LARGE;
                end else if ((r_nonempty && head_ok) || bump_ok) begin
                    n_index   = grant_index;
                    n_address = r_pool_base + fbpa_pkg::ADDR_W'(offset);
                    if (r_nonempty && head_ok) begin
                        ram_re = 1'b1;
                    end else begin
                        n_bump = r_bump + 1'b1;
                    end
                end else begin
                    n_status = fbpa_pkg::ST_EXHAUSTED;
                end
            end else begin
                if (bad_free) begin
                    n_status = fbpa_pkg::ST_BAD_FREE;
                end else begin
                    // push: link the freed block in front of the old head
                    ram_we     = 1'b1;
                    n_head     = i_free_index;
                    n_nonempty = 1'b1;
                end
            end
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= fbpa_pkg::S_IDLE;
            r_head      <= '0;
            r_nonempty  <= 1'b0;
            r_bump      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_head      <= n_head;
            r_nonempty  <= n_nonempty;
            r_bump      <= n_bump;
            r_out_valid <= n_out_valid;
        end
    end

    // result payload
    always_ff @(posedge i_clk) begin
        r_status  <= n_status;
        r_index   <= n_index;
        r_address <= n_address;
    end

    assign o_out_valid     = r_out_valid;
    assign o_status        = r_status;
    assign o_block_index   = r_index;
    assign o_block_address = r_address;

    // link RAM: end flag and next index for each listed block
    fbpa_ram #(
        .WIDTH (fbpa_pkg::LINK_W),
        .DEPTH (DEPTH)
    ) u_link_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

endmodule

`default_nettype wire

// File: src/fbpa_ram.sv
// Generic single-write, single-read RAM with a registered read port.
`default_nettype none

module fbpa_ram #(
    parameter int WIDTH = 9,
    parameter int DEPTH = 256
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // registered read port
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

`default_nettype wire
